[rtl/lgs_pkg.sv]
// Shared definitions for the life grid stepper: operation codes, field widths
// and the payload structs of the input and result channels. No dependencies.
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int GRID_SIZE_DEF = 32;  // default edge length of the square grid
  localparam int FIELD_ROWS    = 32;  // rows and columns that the result fields can carry
  localparam int ROW_IDX_W     = 5;
  localparam int ROW_BITS_W    = 32;
  localparam int OP_W          = 2;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP = 2'd1;
  localparam logic [OP_W-1:0] OP_SHOW = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]  out_row;
    logic [ROW_BITS_W-1:0] out_bits;
    logic                  last_row;
  } out_item_t;

endpackage

[rtl/lgs_stream_if.sv]
// Valid/ready stream channel carrying one payload struct per beat.
// Payload types come from lgs_pkg.
`timescale 1ns / 1ps

interface lgs_stream_if #(
  parameter type T = lgs_pkg::in_item_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/lgs_grid_mem.sv]
// Grid storage: one synchronous RAM row per grid row, one write port and one
// read port with registered read data. Per-row valid bits make unwritten rows read as dead.
`timescale 1ns / 1ps

module lgs_grid_mem #(
  parameter int DEPTH = lgs_pkg::GRID_SIZE_DEF,
  parameter int WIDTH = lgs_pkg::GRID_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_vld_r;
  logic [WIDTH-1:0] q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r     <= mem[rd_addr];
      q_vld_r <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

[rtl/lgs_row_rule.sv]
// B3/S23 rule for one whole row: takes the rows north, middle and south and
// returns the next middle row, wrapping columns at the edges. Pure logic; the
// default width comes from lgs_pkg.
`timescale 1ns / 1ps

module lgs_row_rule #(
  parameter int WIDTH = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic [WIDTH-1:0] north,
  input  logic [WIDTH-1:0] mid,
  input  logic [WIDTH-1:0] south,
  output logic [WIDTH-1:0] next_row
);

  // w[c] holds column c-1, e[c] holds column c+1, both wrapping
  logic [WIDTH-1:0] n_w, n_e, m_w, m_e, s_w, s_e;

  assign n_w = {north[WIDTH-2:0], north[WIDTH-1]};
  assign n_e = {north[0], north[WIDTH-1:1]};
  assign m_w = {mid[WIDTH-2:0], mid[WIDTH-1]};
  assign m_e = {mid[0], mid[WIDTH-1:1]};
  assign s_w = {south[WIDTH-2:0], south[WIDTH-1]};
  assign s_e = {south[0], south[WIDTH-1:1]};

  always_comb begin
    logic [3:0] cnt;
    next_row = '0;
    for (int c = 0; c < WIDTH; c++) begin
      cnt = 4'(n_w[c]) + 4'(north[c]) + 4'(n_e[c]) + 4'(m_w[c]) + 4'(m_e[c])
          + 4'(s_w[c]) + 4'(south[c]) + 4'(s_e[c]);
      next_row[c] = (cnt == 4'd3) || (mid[c] && (cnt == 4'd2));
    end
  end

endmodule

[rtl/life_grid_stepper_top.sv]
// Life grid stepper: a GRID_SIZE x GRID_SIZE toroidal Game of Life board (B3/S23)
// held in one synchronous RAM, one row per entry. A load beat writes one row. A
// step beat sweeps the RAM once: three priming reads, then one row read, computed
// and written back per cycle; the old row being rewritten and the one north of it
// are kept in a two-row window and row 0 is saved for the wrap at the bottom. Step
// and show beats then emit min(GRID_SIZE, 32) result beats, one per cycle while
// out_chan is ready; the first one passes through the RAM read register and then
// the output register. Reset clears the grid at once through per-row valid bits;
// there is no clearing pass. The block takes the next input beat once the last
// row has left the RAM.
// Depends on lgs_pkg, lgs_stream_if, lgs_grid_mem and lgs_row_rule.
`timescale 1ns / 1ps

module life_grid_stepper_top #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  lgs_stream_if.sink          in_chan,
  lgs_stream_if.source        out_chan
);

  localparam int AW        = $clog2(GRID_SIZE);
  localparam int XW        = (GRID_SIZE > lgs_pkg::ROW_BITS_W) ? GRID_SIZE
                                                                : lgs_pkg::ROW_BITS_W;
  localparam int EMIT_ROWS = (GRID_SIZE < lgs_pkg::FIELD_ROWS) ? GRID_SIZE
                                                                : lgs_pkg::FIELD_ROWS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE0 = 3'd1;
  localparam logic [2:0] ST_PRE1 = 3'd2;
  localparam logic [2:0] ST_PRE2 = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [AW-1:0]                  row_r, row_nxt;
  logic [lgs_pkg::ROW_IDX_W-1:0]  emit_r, emit_nxt;
  logic [GRID_SIZE-1:0]           north_r, north_nxt;
  logic [GRID_SIZE-1:0]           mid_r, mid_nxt;
  logic [GRID_SIZE-1:0]           top_r, top_nxt;
  logic                           pend_r, pend_nxt;
  logic [lgs_pkg::ROW_IDX_W-1:0]  pend_row_r, pend_row_nxt;
  logic                           pend_last_r, pend_last_nxt;
  logic                           out_valid_r, out_valid_nxt;
  lgs_pkg::out_item_t             out_r, out_nxt;

  logic                           wr_en, rd_en;
  logic [AW-1:0]                  wr_addr, rd_addr;
  logic [GRID_SIZE-1:0]           wr_data, rd_data, south, next_row;
  logic                           in_fire, load_out;
  logic [XW-1:0]                  in_ext, out_ext;

  lgs_grid_mem #(
    .DEPTH (GRID_SIZE),
    .WIDTH (GRID_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgs_row_rule #(
    .WIDTH (GRID_SIZE)
  ) u_rule (
    .north    (north_r),
    .mid      (mid_r),
    .south    (south),
    .next_row (next_row)
  );

  assign in_chan.ready  = (state_r == ST_IDLE) && !pend_r;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // The bottom row wraps onto the saved old row 0.
  assign south    = (int'(row_r) + 1 < GRID_SIZE) ? rd_data : top_r;
  assign load_out = pend_r && (!out_valid_r || out_chan.ready);
  assign in_ext   = XW'(in_chan.data.row_bits);
  assign out_ext  = XW'(rd_data);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    emit_nxt      = emit_r;
    north_nxt     = north_r;
    mid_nxt       = mid_r;
    top_nxt       = top_r;
    pend_nxt      = pend_r;
    pend_row_nxt  = pend_row_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = row_r;
    wr_data       = next_row;
    rd_en         = 1'b0;
    rd_addr       = row_r;

    // Drain the output register, then refill it from the pending RAM row.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt    = 1'b1;
      out_nxt.out_row  = pend_row_r;
      out_nxt.out_bits = out_ext[lgs_pkg::ROW_BITS_W-1:0];
      out_nxt.last_row = pend_last_r;
      pend_nxt         = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_chan.data.operation == lgs_pkg::OP_LOAD) begin
            if (int'(in_chan.data.row_index) < GRID_SIZE) begin
              wr_en   = 1'b1;
              wr_addr = AW'(in_chan.data.row_index);
              wr_data = in_ext[GRID_SIZE-1:0];
            end
          end else if (in_chan.data.operation == lgs_pkg::OP_STEP) begin
            state_nxt = ST_PRE0;
          end else if (in_chan.data.operation == lgs_pkg::OP_SHOW) begin
            state_nxt = ST_EMIT;
            emit_nxt  = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PRE0: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(GRID_SIZE - 1);
        state_nxt = ST_PRE1;
      end
      ST_PRE1: begin
        // Old bottom row arrives here: it is north of row 0.
        north_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ST_PRE2;
      end
      ST_PRE2: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(1);
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        wr_en     = 1'b1;
        wr_addr   = row_r;
        wr_data   = next_row;
        north_nxt = mid_r;
        mid_nxt   = south;
        if (int'(row_r) + 2 < GRID_SIZE) begin
          rd_en   = 1'b1;
          rd_addr = row_r + AW'(2);
        end
        if (row_r == AW'(GRID_SIZE - 1)) begin
          state_nxt = ST_EMIT;
          emit_nxt  = '0;
          row_nxt   = '0;
        end else begin
          row_nxt = row_r + AW'(1);
        end
      end
      ST_EMIT: begin
        if (!pend_r || load_out) begin
          rd_en         = 1'b1;
          rd_addr       = AW'(emit_r);
          pend_nxt      = 1'b1;
          pend_row_nxt  = emit_r;
          pend_last_nxt = (emit_r == lgs_pkg::ROW_IDX_W'(EMIT_ROWS - 1));
          if (emit_r == lgs_pkg::ROW_IDX_W'(EMIT_ROWS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt = emit_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Old row 0 arrives in ST_PRE2, before the first row is rewritten: start the window.
    if (state_r == ST_PRE2) begin
      mid_nxt = rd_data;
      top_nxt = rd_data;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      emit_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      emit_r      <= emit_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    north_r     <= north_nxt;
    mid_r       <= mid_nxt;
    top_r       <= top_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_last_r <= pend_last_nxt;
    out_r       <= out_nxt;
  end

endmodule

[bench/life_grid_stepper_top_tb.sv]
// Self-checking bench for life_grid_stepper_top: loads, steps and shows a toroidal
// B3/S23 board and checks every emitted row against a board model kept here.
// Depends on lgs_pkg, lgs_stream_if and the life_grid_stepper_top RTL.
`timescale 1ns / 1ps

module life_grid_stepper_top_tb;
  import lgs_pkg::*;

  localparam int GRID      = GRID_SIZE_DEF;
  localparam int EMIT_ROWS = (GRID < FIELD_ROWS) ? GRID : FIELD_ROWS;
  localparam logic [ROW_BITS_W-1:0] COL_MASK =
      (GRID >= ROW_BITS_W) ? '1 : ((32'd1 << GRID) - 32'd1);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int TRAIL_CYCLES = 80;   // > one full sweep plus read latency

  typedef logic [ROW_BITS_W-1:0] board_row_t;

  logic clk = 1'b0;
  logic rst_n;

  lgs_stream_if #(.T(in_item_t))  in_if ();
  lgs_stream_if #(.T(out_item_t)) out_if ();

  life_grid_stepper_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  board_row_t board_q [GRID];
  out_item_t  expected_rows_q [$];

  int fail_count   = 0;
  int loads_sent   = 0;
  int steps_sent   = 0;
  int shows_sent   = 0;
  int ignored_sent = 0;
  int rows_checked = 0;
  int burst_left   = 0;
  bit no_gaps      = 1'b0;

  // ---------------------------------------------------------------- board model

  function automatic void advance_board();
    board_row_t next_q [GRID];
    int live;
    for (int r = 0; r < GRID; r++) begin
      next_q[r] = '0;
      for (int c = 0; c < GRID; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0)
              live += board_q[(r + dr + GRID) % GRID][(c + dc + GRID) % GRID];
          end
        end
        next_q[r][c] = (live == 3) || (board_q[r][c] && live == 2);
      end
    end
    board_q = next_q;
  endfunction

  function automatic void queue_board_rows();
    out_item_t row;
    for (int r = 0; r < EMIT_ROWS; r++) begin
      row.out_row  = r[ROW_IDX_W-1:0];
      row.out_bits = board_q[r];
      row.last_row = (r == EMIT_ROWS - 1);
      expected_rows_q.push_back(row);
    end
  endfunction

  function automatic void apply_beat(in_item_t it);
    case (it.operation)
      OP_LOAD: begin
        loads_sent++;
        if (it.row_index < GRID)
          board_q[it.row_index] = it.row_bits & COL_MASK;
      end
      OP_STEP: begin
        steps_sent++;
        advance_board();
        queue_board_rows();
      end
      OP_SHOW: begin
        shows_sent++;
        queue_board_rows();
      end
      default: ignored_sent++;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic board_row_t rand_row();
    board_row_t bits;
    case ($urandom_range(0, 4))
      0: bits = $urandom;
      1: bits = $urandom & $urandom;
      2: bits = $urandom & $urandom & $urandom;
      3: bits = $urandom | $urandom;
      default: bits = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
    endcase
    return bits;
  endfunction

  // Hold the beat until it is taken; valid stays high between back-to-back beats.
  task automatic send_beat(logic [OP_W-1:0] op, logic [ROW_IDX_W-1:0] idx,
                           logic [ROW_BITS_W-1:0] bits);
    in_item_t it;
    int gap;
    it.operation = op;
    it.row_index = idx;
    it.row_bits  = bits;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    apply_beat(it);
  endtask

  task automatic send_random_op(logic [OP_W-1:0] op);
    send_beat(op, ROW_IDX_W'($urandom_range(0, 31)), $urandom);
  endtask

  // Drop valid and hold off until every queued row has been seen.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_rows_q.size() != 0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_cleared_board();
    send_beat(OP_SHOW, '0, '0);
  endtask

  task automatic test_row_extremes();
    send_beat(OP_LOAD, 5'd0, 32'hFFFF_FFFF);
    send_beat(OP_LOAD, 5'd31, 32'hFFFF_FFFF);
    send_beat(OP_LOAD, 5'd5, 32'h8000_0001);
    send_beat(OP_SHOW, 5'd0, 32'h0);
    send_beat(OP_STEP, 5'd31, 32'hFFFF_FFFF);
  endtask

  // Glider loaded across the bottom-right corner so its steps wrap both ways; rows not loaded here keep earlier state.
  task automatic test_corner_glider();
    send_beat(OP_LOAD, 5'd5, 32'h0);
    send_beat(OP_LOAD, 5'd30, 32'h8000_0000);
    send_beat(OP_LOAD, 5'd31, 32'h0000_0001);
    send_beat(OP_LOAD, 5'd0, 32'hC000_0001);
    repeat (4) send_beat(OP_STEP, '0, '0);
  endtask

  task automatic test_unused_fields();
    send_beat(OP_UNUSED, 5'd31, 32'hFFFF_FFFF);
    send_beat(OP_UNUSED, 5'd0, 32'h0);
    send_beat(OP_SHOW, 5'd31, 32'hFFFF_FFFF);
    send_random_op(OP_STEP);
    send_beat(OP_LOAD, 5'd31, 32'h0);
  endtask

  task automatic test_random_traffic(int target);
    int kind;
    while (loads_sent + steps_sent + shows_sent < target) begin
      kind = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 4) == 0);
      if (kind < 60) begin
        repeat ($urandom_range(1, 8))
          send_beat(OP_LOAD, ROW_IDX_W'($urandom_range(0, 31)), rand_row());
        repeat ($urandom_range(1, 3)) send_random_op(OP_STEP);
        if ($urandom_range(0, 3) == 0) send_random_op(OP_SHOW);
      end else if (kind < 65) begin
        // wipe the board, seed a few rows, let it evolve
        for (int r = 0; r < GRID; r++)
          send_beat(OP_LOAD, ROW_IDX_W'(r), ($urandom_range(0, 3) == 0) ? rand_row() : '0);
        repeat ($urandom_range(2, 4)) send_random_op(OP_STEP);
      end else if (kind < 85) begin
        case ($urandom_range(0, 2))
          0: send_random_op(OP_UNUSED);
          1: send_random_op(OP_SHOW);
          default: send_random_op(OP_STEP);
        endcase
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat(OP_LOAD, ROW_IDX_W'($urandom_range(0, 31)), rand_row());
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    for (int r = 0; r < GRID; r++) board_q[r] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_cleared_board();
    test_row_extremes();
    test_corner_glider();
    test_unused_fields();
    wait_drained();
    test_random_traffic(480);

    wait_drained();
    repeat (TRAIL_CYCLES) @(posedge clk);
    if (expected_rows_q.size() != 0) begin
      $error("%0d board rows never arrived", expected_rows_q.size());
      fail_count++;
    end

    $display("Sent %0d loads, %0d steps, %0d shows and %0d unused-code beats",
             loads_sent, steps_sent, shows_sent, ignored_sent);
    $display("Checked %0d emitted board rows under random gaps and back-pressure",
             rows_checked);
    if (fail_count == 0) begin
      $display("PASS life_grid_stepper_top");
    end else begin
      $display("FAIL life_grid_stepper_top");
    end
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // Stall on a rotating 16-bit pattern, reloaded now and then; bit 0 is forced
  // so every pattern holds a ready bit and no stall goes on forever.
  initial begin
    logic [15:0] stall_pattern;
    int          pattern_age;
    out_if.ready  = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_age   = 0;
    forever begin
      @(posedge clk);
      out_if.ready  <= stall_pattern[0];
      stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
      pattern_age++;
      if (pattern_age == 160) begin
        pattern_age = 0;
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom) | 16'h0001;
          2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
          default: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp_row;
    out_item_t got_row;
    if (rst_n && out_if.valid && out_if.ready) begin
      got_row = out_if.data;
      if (expected_rows_q.size() == 0) begin
        $error("unexpected board row %0d: %h", got_row.out_row, got_row.out_bits);
        fail_count++;
      end else begin
        exp_row = expected_rows_q.pop_front();
        rows_checked++;
        if (got_row.out_row !== exp_row.out_row) begin
          $error("out_row mismatch: expected %0d, got %0d", exp_row.out_row, got_row.out_row);
          fail_count++;
        end
        if (got_row.out_bits !== exp_row.out_bits) begin
          $error("out_bits mismatch: expected %h, got %h", exp_row.out_bits, got_row.out_bits);
          fail_count++;
        end
        if (got_row.last_row !== exp_row.last_row) begin
          $error("last_row mismatch: expected %0b, got %0b", exp_row.last_row,
                 got_row.last_row);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any beat on either channel counts as progress.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no beat for %0d cycles, %0d rows outstanding", STALL_LIMIT,
             expected_rows_q.size());
    $display("FAIL life_grid_stepper_top");
    $finish;
  end

endmodule
